// ----- sv/teq_pkg.sv -----
// Shared types and constants for the timer expiry queue.
package teq_pkg;

  localparam int unsigned IdW     = 4;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned MaxOut  = 16;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_STOP  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EMIT = 2'd2
  } state_e;

  // Command broadcast combinationally to every cell.
  typedef struct packed {
    logic             start;   // write entry of sel_id
    logic             stop;    // clear entry of sel_id
    logic             fire;    // winner of the last scan fires
    logic             scan;    // keep the done marks of fired entries
    logic [5:0]       sel_id;
    logic [TimeW-1:0] expiry;
    logic [PeriodW-1:0] period;
    logic             repeats;
    logic [TimeW-1:0] now;
  } cell_cmd_t;

  // Candidate carried along the chain.
  typedef struct packed {
    logic             valid;
    logic             more;    // a second due entry was seen on the way
    logic [5:0]       id;
    logic [TimeW-1:0] expiry;
  } cand_t;

endpackage

// ----- sv/timer_expiry_queue.sv -----
// Timer expiry queue: a row of TIMER_COUNT timer cells behind one sequencer.
// s_axis carries requests: tuser holds the request kind (start, stop, tick),
// tdata the timer id, expiry, reload interval, periodic flag and tick time.
// Start and stop are taken while the sequencer is idle and give no result.
// A tick scans the cell chain and then loads the earliest due timer into the
// result register once that register is free; each further due timer takes
// another scan. A tick with nothing due gives a single result with tuser
// (fired) low. tlast marks the final result of a tick.
// s_axis_tready is low from the tick transaction until its last result is
// loaded; the next request is taken the cycle after.
// m_axis holds one result; while m_axis_tready is low it stays put and the
// sequencer waits with the next result of the tick.
// Reset empties all slots at once; no clearing pass is needed.
module timer_expiry_queue #(
  parameter int unsigned TIMER_COUNT = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  // timer_id[3:0], expiry_time[67:4], reload_interval[99:68], periodic[100],
  // now_time[164:101], zero fill
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // fired[0]
  output logic         m_axis_tuser,
  // fired_timer_id[3:0], fired_expiry[67:4], zero fill
  output logic [71:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  teq_pkg::cell_cmd_t cmd;
  teq_pkg::cand_t     chain [TIMER_COUNT+1];
  logic [3:0]         c_id;
  logic [63:0]        c_exp;

  assign chain[TIMER_COUNT] = '0;

  for (genvar g = 0; g < TIMER_COUNT; g++) begin : g_cell
    teq_cell #(.CellId(6'(g))) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .cand_i (chain[g+1]),
      .cand_o (chain[g])
    );
  end

  teq_ctrl #(.TimerCount(TIMER_COUNT), .ScanCycles(TIMER_COUNT)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_i       (s_axis_tuser),
    .id_i        (s_axis_tdata[3:0]),
    .exp_i       (s_axis_tdata[67:4]),
    .per_i       (s_axis_tdata[99:68]),
    .rep_i       (s_axis_tdata[100]),
    .now_i       (s_axis_tdata[164:101]),
    .cmd_o       (cmd),
    .best_i      (chain[0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_fired_o (m_axis_tuser),
    .out_id_o    (c_id),
    .out_exp_o   (c_exp),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, c_exp, c_id};

endmodule

// ----- sv/teq_cell.sv -----
// One timer slot: holds its entry and passes the best due candidate on.
module teq_cell #(
  parameter logic [5:0] CellId = 6'd0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  teq_pkg::cell_cmd_t cmd_i,
  input  teq_pkg::cand_t     cand_i,
  output teq_pkg::cand_t     cand_o
);

  logic                            used_q, done_q, rep_q;
  logic [teq_pkg::TimeW-1:0]       exp_q;
  logic [teq_pkg::PeriodW-1:0]     per_q;
  teq_pkg::cand_t                  cand_q, cand_d;
  logic                            mine, due;
  logic [teq_pkg::TimeW-1:0]       step, sum;
  logic                            carry;

  assign mine = (cmd_i.sel_id == CellId);
  assign due  = used_q && !done_q && (exp_q <= cmd_i.now);
  assign step = (per_q == '0) ? teq_pkg::TimeW'(1) : teq_pkg::TimeW'(per_q);
  assign {carry, sum} = {1'b0, cmd_i.now} + {1'b0, step};

  // Less-or-equal hands ties to the lower id (chain runs from high id to low).
  always_comb begin
    cand_d = cand_i;
    if (due && cand_i.valid) cand_d.more = 1'b1;
    if (due && (!cand_i.valid || exp_q <= cand_i.expiry)) begin
      cand_d.valid  = 1'b1;
      cand_d.id     = CellId;
      cand_d.expiry = exp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      done_q <= 1'b0;
      rep_q  <= 1'b0;
      exp_q  <= '0;
      per_q  <= '0;
      cand_q <= '0;
    end else begin
      cand_q <= cand_d;
      if (cmd_i.start && mine) begin
        used_q <= 1'b1;
        exp_q  <= cmd_i.expiry;
        per_q  <= cmd_i.period;
        rep_q  <= cmd_i.repeats;
      end else if (cmd_i.stop && mine) begin
        used_q <= 1'b0;
      end else if (cmd_i.fire && mine) begin
        done_q <= 1'b1;
        if (rep_q) exp_q <= carry ? '1 : sum;
        else       used_q <= 1'b0;
      end
      if (!cmd_i.scan && !cmd_i.fire) done_q <= 1'b0;
    end
  end

  assign cand_o = cand_q;

endmodule

// ----- sv/teq_ctrl.sv -----
// Sequencer: takes requests, runs chain scans and emits results.
module teq_ctrl #(
  parameter int unsigned TimerCount = 16,
  parameter int unsigned ScanCycles = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                req_i,
  input  logic [teq_pkg::IdW-1:0]   id_i,
  input  logic [teq_pkg::TimeW-1:0] exp_i,
  input  logic [teq_pkg::PeriodW-1:0] per_i,
  input  logic                      rep_i,
  input  logic [teq_pkg::TimeW-1:0] now_i,
  output teq_pkg::cell_cmd_t        cmd_o,
  input  teq_pkg::cand_t            best_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      out_fired_o,
  output logic [teq_pkg::IdW-1:0]   out_id_o,
  output logic [teq_pkg::TimeW-1:0] out_exp_o,
  output logic                      out_last_o
);

  localparam int unsigned CntW = $clog2(ScanCycles + 1);

  teq_pkg::state_e           state_q, state_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [4:0]                nout_q, nout_d;
  logic [teq_pkg::TimeW-1:0] now_q, now_d;
  logic                      ov_q, ov_d;
  logic                      of_q, of_d, ol_q, ol_d;
  logic [teq_pkg::IdW-1:0]   oid_q, oid_d;
  logic [teq_pkg::TimeW-1:0] oexp_q, oexp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= teq_pkg::ST_IDLE;
      cnt_q   <= '0;
      nout_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nout_q  <= nout_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    of_q   <= of_d;
    ol_q   <= ol_d;
    oid_q  <= oid_d;
    oexp_q <= oexp_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    nout_d  = nout_q;
    now_d   = now_q;
    ov_d    = ov_q;
    of_d    = of_q;
    ol_d    = ol_q;
    oid_d   = oid_q;
    oexp_d  = oexp_q;
    in_ready_o = 1'b0;
    cmd_o = '0;
    cmd_o.now = now_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      teq_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.sel_id  = 6'(id_i);
        cmd_o.expiry  = exp_i;
        cmd_o.period  = per_i;
        cmd_o.repeats = rep_i;
        if (in_valid_i) begin
          if (req_i == teq_pkg::REQ_START && 32'(id_i) < TimerCount) cmd_o.start = 1'b1;
          if (req_i == teq_pkg::REQ_STOP  && 32'(id_i) < TimerCount) cmd_o.stop  = 1'b1;
          if (req_i == teq_pkg::REQ_TICK) begin
            now_d   = now_i;
            cnt_d   = '0;
            nout_d  = '0;
            state_d = teq_pkg::ST_SCAN;
          end
        end
      end
      teq_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == ScanCycles - 1) state_d = teq_pkg::ST_EMIT;
      end
      teq_pkg::ST_EMIT: begin
        cmd_o.scan = 1'b1;
        // wait for the output register to free before loading a result
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          if (best_i.valid) begin
            cmd_o.fire   = 1'b1;
            cmd_o.sel_id = best_i.id;
            of_d   = 1'b1;
            oid_d  = best_i.id[teq_pkg::IdW-1:0];
            oexp_d = best_i.expiry;
            nout_d = nout_q + 1'b1;
            cnt_d  = '0;
            // the winner is done after firing, so only a second due entry means more
            if (!best_i.more || 32'(nout_q) == teq_pkg::MaxOut - 1) begin
              ol_d = 1'b1;
              state_d = teq_pkg::ST_IDLE;
            end else begin
              ol_d = 1'b0;
              state_d = teq_pkg::ST_SCAN;
            end
          end else begin
            of_d = 1'b0; oid_d = '0; oexp_d = '0; ol_d = 1'b1;
            state_d = teq_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = teq_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_fired_o = of_q;
  assign out_id_o    = oid_q;
  assign out_exp_o   = oexp_q;
  assign out_last_o  = ol_q;

`ifndef SYNTHESIS
  a_emit_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fire |=> ov_q && of_q) else $error("fire without result");
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == teq_pkg::ST_SCAN) |-> !in_ready_o) else $error("ready during scan");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(oexp_q)) else $error("result lost");
`endif

endmodule
